@@ hdl/rrb_pkg.sv @@
// Shared constants, codes and control types for the receive ring buffer.
package rrb_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W        = 10;
  localparam int FILL_W       = 7;
  localparam int VALUE_W      = 64;
  localparam int BYTE_W       = 8;
  localparam int NB_W         = 4;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_PEEK    = 3'd2;
  localparam logic [2:0] OP_DISCARD = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } rrb_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
    logic finish;
  } rrb_cmd_t;

  typedef struct packed {
    logic need_fetch;
    logic last_fetch;
  } rrb_sts_t;

endpackage

@@ hdl/rrb_if.sv @@
// Valid/ready channel interfaces for operations in and results out.
interface rrb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [1:0] size_code;
  logic [7:0] peek_offset;
  logic [7:0] drop_amount;
  logic [7:0] push_byte;
  modport source (output valid, opcode, size_code, peek_offset, drop_amount, push_byte,
                  input ready);
  modport sink   (input valid, opcode, size_code, peek_offset, drop_amount, push_byte,
                  output ready);
endinterface

interface rrb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        ok;
  logic [6:0]  fill_level;
  modport source (output valid, value, ok, fill_level, input ready);
  modport sink   (input valid, value, ok, fill_level, output ready);
endinterface

@@ hdl/rx_ring_buffer_be_reader.sv @@
// Top level of the receive byte ring buffer with big-endian reader.
//
// Usage: one operation enters per transaction on in_ch (push, read, peek,
// discard, flush) and exactly one result leaves per transaction on out_ch
// with the assembled value, an ok flag and the fill level afterwards.
// A transaction is taken when valid and ready are both high at a rising edge.
// Sequencing: the block works on one operation at a time. A push, discard,
// flush, short read or short peek passes from acceptance through the execute
// and done states to the result register; a read or peek also passes through
// the fetch state once per byte and then a drain state, because the bytes
// come one per cycle from the single read port of the byte store.
// The next operation is accepted in the idle state that follows the result
// load, even while that result still waits in the output register.
// Stall: if the receiver holds out_ch.ready low, the finished result of the
// following operation waits inside the block and no further operation is taken.
// Reset (rst_n low, synchronous): indices and fill count go to zero and the
// output register empties; byte store contents are left as they are.
module rx_ring_buffer_be_reader
  import rrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rrb_in_if.sink    in_ch,
  rrb_out_if.source out_ch
);

  rrb_cmd_t cmd;
  rrb_sts_t sts;

  // sequence each transaction
  rrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  // hold the bytes, advance the indices and assemble the value
  rrb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_ch.opcode),
    .in_size_code   (in_ch.size_code),
    .in_peek_offset (in_ch.peek_offset),
    .in_drop_amount (in_ch.drop_amount),
    .in_push_byte   (in_ch.push_byte),
    .out_value      (out_ch.value),
    .out_ok         (out_ch.ok),
    .out_fill_level (out_ch.fill_level)
  );

endmodule

@@ hdl/rrb_ctrl.sv @@
// Operation sequencer: steps each transaction through execute, fetch and output.
module rrb_ctrl
  import rrb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_ready,
  input  rrb_sts_t sts,
  output rrb_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid
);

  rrb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_busy  = out_valid_r && !out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_fetch ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.last_fetch) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready)      out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/rrb_dp.sv @@
// Datapath: byte store, indices, fill count, byte assembly and result register.
module rrb_dp
  import rrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rrb_cmd_t           cmd,
  output rrb_sts_t           sts,
  input  logic [2:0]         in_opcode,
  input  logic [1:0]         in_size_code,
  input  logic [7:0]         in_peek_offset,
  input  logic [7:0]         in_drop_amount,
  input  logic [7:0]         in_push_byte,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_ok,
  output logic [FILL_W-1:0]  out_fill_level
);

  logic [BYTE_W-1:0]  mem [BUFFER_DEPTH];

  logic [2:0]         op_r;
  logic [1:0]         size_r;
  logic [7:0]         offset_r;
  logic [7:0]         drop_r;
  logic [7:0]         byte_r;

  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [NB_W-1:0]    cnt_r, cnt_nxt;
  logic               ok_r, ok_nxt;
  logic [VALUE_W-1:0] acc_r;
  logic [BYTE_W-1:0]  rdata_r;
  logic               rd_pend_r;

  logic [VALUE_W-1:0] value_r;
  logic               res_ok_r;
  logic [FILL_W-1:0]  res_fill_r;

  logic [NB_W-1:0]    nbytes;
  logic [CMP_W-1:0]   fill_w, start_sum, adv_sum, clamp_drop;
  logic               enough_read, enough_peek, mem_wr;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_sum(input logic [CMP_W-1:0] s);
    return (s >= CMP_W'(BUFFER_DEPTH)) ? IDX_W'(s - CMP_W'(BUFFER_DEPTH)) : IDX_W'(s);
  endfunction

  assign nbytes      = NB_W'(1) << size_r;
  assign fill_w      = CMP_W'(fill_r);
  assign enough_read = fill_w >= CMP_W'(nbytes);
  assign enough_peek = (CMP_W'(offset_r) + CMP_W'(nbytes)) <= fill_w;
  assign start_sum   = CMP_W'(rd_idx_r) + CMP_W'(offset_r);
  assign clamp_drop  = (CMP_W'(drop_r) > fill_w) ? fill_w : CMP_W'(drop_r);

  assign sts.need_fetch = ((op_r == OP_READ) && enough_read) ||
                          ((op_r == OP_PEEK) && enough_peek);
  assign sts.last_fetch = (cnt_r == NB_W'(1));

  assign mem_wr = cmd.exec && (op_r == OP_PUSH) && (fill_w < CMP_W'(BUFFER_DEPTH));

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    ok_nxt     = ok_r;
    adv_sum    = '0;
    if (cmd.exec) begin
      ok_nxt = 1'b0;
      unique case (op_r)
        OP_PUSH: begin
          if (mem_wr) begin
            wr_idx_nxt = wrap_inc(wr_idx_r);
            fill_nxt   = fill_r + 1'b1;
            ok_nxt     = 1'b1;
          end
        end
        OP_READ, OP_PEEK: begin
          ok_nxt   = sts.need_fetch;
          addr_nxt = (op_r == OP_READ) ? rd_idx_r : wrap_sum(start_sum);
          cnt_nxt  = nbytes;
        end
        OP_DISCARD: begin
          adv_sum    = CMP_W'(rd_idx_r) + clamp_drop;
          rd_idx_nxt = wrap_sum(adv_sum);
          fill_nxt   = CNT_W'(fill_w - clamp_drop);
          ok_nxt     = 1'b1;
        end
        OP_FLUSH: begin
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          fill_nxt   = '0;
          ok_nxt     = 1'b1;
        end
        default: ok_nxt = 1'b0;
      endcase
    end
    if (cmd.fetch) begin
      addr_nxt = wrap_inc(addr_r);
      cnt_nxt  = cnt_r - 1'b1;
    end
    // a read consumes its bytes only once the value has been assembled
    if (cmd.finish && (op_r == OP_READ) && ok_r) begin
      adv_sum    = CMP_W'(rd_idx_r) + CMP_W'(nbytes);
      rd_idx_nxt = wrap_sum(adv_sum);
      fill_nxt   = fill_r - CNT_W'(nbytes);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      fill_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_idx_r  <= rd_idx_nxt;
      wr_idx_r  <= wr_idx_nxt;
      fill_r    <= fill_nxt;
      rd_pend_r <= cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      size_r   <= in_size_code;
      offset_r <= in_peek_offset;
      drop_r   <= in_drop_amount;
      byte_r   <= in_push_byte;
    end
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    ok_r   <= ok_nxt;
    if (cmd.exec) acc_r <= '0;
    else if (rd_pend_r) acc_r <= {acc_r[VALUE_W-BYTE_W-1:0], rdata_r};
    if (cmd.finish) begin
      value_r    <= acc_r;
      res_ok_r   <= ok_r;
      res_fill_r <= FILL_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) mem[wr_idx_r] <= byte_r;
    if (cmd.fetch) rdata_r <= mem[addr_r];
  end

  assign out_value      = value_r;
  assign out_ok         = res_ok_r;
  assign out_fill_level = res_fill_r;

endmodule
